// ----- rtl/core/lrb_pkg.sv -----
// shared types, codes and reset values for the link reconnect backoff block
`default_nettype none

package lrb_pkg;

    localparam int TIME_W     = 48;
    localparam int DEADLINE_W = TIME_W + 1;
    localparam int DELAY_W    = 32;
    localparam int PORT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // link states
    localparam logic [2:0] ST_DISABLED   = 3'd0;
    localparam logic [2:0] ST_WAITNET    = 3'd1;
    localparam logic [2:0] ST_READY      = 3'd2;
    localparam logic [2:0] ST_CONNECTING = 3'd3;
    localparam logic [2:0] ST_ONLINE     = 3'd4;
    localparam logic [2:0] ST_BACKOFF    = 3'd5;
    localparam logic [2:0] ST_FAULT      = 3'd6;

    // actions
    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_CONNECT    = 2'd1;
    localparam logic [1:0] ACT_DISCONNECT = 2'd2;

    // event modes
    localparam logic [2:0] MODE_TICK         = 3'd0;
    localparam logic [2:0] MODE_CONNECTING   = 3'd1;
    localparam logic [2:0] MODE_CONNECTED    = 3'd2;
    localparam logic [2:0] MODE_DISCONNECTED = 3'd3;
    localparam logic [2:0] MODE_RESTART      = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_SET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID_SET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_PORT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BACKOFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKOFF   = 3'd5;

    localparam logic [DELAY_W-1:0] BASE_BACKOFF_RST = 32'd1000;
    localparam logic [DELAY_W-1:0] MAX_BACKOFF_RST  = 32'd60000;

    typedef struct packed {
        logic               link_enabled;
        logic               endpoint_set;
        logic               device_id_set;
        logic [PORT_W-1:0]  server_port;
        logic [DELAY_W-1:0] base_backoff;
        logic [DELAY_W-1:0] max_backoff;
    } lrb_cfg_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic              network_up;
        logic [TIME_W-1:0] time_ms;
        logic              auth_failed;
    } lrb_item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] link_state;
    } lrb_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/link_reconnect_backoff_fsm.sv -----
// top level: request input register, link state machine and result register
// an accepted request waits in the input register until the result register is free
// throughput: one request per cycle unless stalled, the state update is combinational
// an output stall holds the result while the input register may still take one request
// reset: asynchronous, clears both valid flags, state goes to disabled with delay 1000
// config writes are taken every cycle and applied by a restart request
`default_nettype none

module link_reconnect_backoff_fsm (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [2:0]                      mode,
    input  wire logic                            network_up,
    input  wire logic [lrb_pkg::TIME_W-1:0]      time_ms,
    input  wire logic                            auth_failed,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           action,
    output logic [2:0]                           link_state,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lrb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lrb_pkg::*;

    lrb_cfg_t    cfg;
    lrb_item_t   item_reg;
    lrb_result_t step_result;
    lrb_result_t result_reg;
    logic        in_vld_reg, in_vld_next;
    logic        out_vld_reg, out_vld_next;
    logic        advance;
    logic        in_take;

    assign cfg_ready = 1'b1;

    lrb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // request moves into the state machine when the result register is free
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    lrb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    assign in_vld_next  = in_take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode        <= mode;
            item_reg.network_up  <= network_up;
            item_reg.time_ms     <= time_ms;
            item_reg.auth_failed <= auth_failed;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_vld_reg;
    assign action     = result_reg.action;
    assign link_state = result_reg.link_state;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advanced request lost before result register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_vld_reg && $stable(item_reg))
        else $error("pending request dropped while stalled");

endmodule

`default_nettype wire

// ----- rtl/core/lrb_cfg.sv -----
// configuration register file, written through the config request channel
`default_nettype none

module lrb_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [lrb_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [lrb_pkg::CFG_DATA_W-1:0]  wr_data,
    output lrb_pkg::lrb_cfg_t                    cfg
);
    import lrb_pkg::*;

    lrb_cfg_t cfg_reg;
    lrb_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_LINK_ENABLED:  cfg_next.link_enabled  = wr_data[0];
                REG_ENDPOINT_SET:  cfg_next.endpoint_set  = wr_data[0];
                REG_DEVICE_ID_SET: cfg_next.device_id_set = wr_data[0];
                REG_SERVER_PORT:   cfg_next.server_port   = wr_data[PORT_W-1:0];
                REG_BASE_BACKOFF:  cfg_next.base_backoff  = wr_data[DELAY_W-1:0];
                REG_MAX_BACKOFF:   cfg_next.max_backoff   = wr_data[DELAY_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_enabled  <= 1'b0;
            cfg_reg.endpoint_set  <= 1'b0;
            cfg_reg.device_id_set <= 1'b0;
            cfg_reg.server_port   <= '0;
            cfg_reg.base_backoff  <= BASE_BACKOFF_RST;
            cfg_reg.max_backoff   <= MAX_BACKOFF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lrb_core.sv -----
// link state machine with applied configuration and capped exponential backoff
`default_nettype none

module lrb_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step_en,
    input  wire lrb_pkg::lrb_item_t item,
    input  wire lrb_pkg::lrb_cfg_t  cfg,
    output lrb_pkg::lrb_result_t result
);
    import lrb_pkg::*;

    // applied configuration, with validity and start delay worked out at restart
    logic                  enabled_reg, enabled_next;
    logic                  cfg_ok_reg, cfg_ok_next;
    logic [DELAY_W-1:0]    start_delay_reg, start_delay_next;
    logic [DELAY_W-1:0]    max_backoff_reg, max_backoff_next;

    logic [2:0]            state_reg, state_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;
    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic [1:0]            act;

    logic                  is_active;
    logic                  new_cfg_ok;
    logic [DELAY_W-1:0]    new_start_delay;
    logic [DELAY_W-1:0]    doubled;
    logic [DEADLINE_W-1:0] now_ext;

    assign is_active = state_reg inside {ST_CONNECTING, ST_ONLINE};
    assign now_ext   = {1'b0, item.time_ms};

    assign new_cfg_ok = cfg.endpoint_set && cfg.device_id_set
                     && (cfg.server_port != '0) && (cfg.base_backoff != '0)
                     && (cfg.max_backoff >= cfg.base_backoff);
    assign new_start_delay = (cfg.base_backoff > DELAY_W'(1)) ? cfg.base_backoff
                                                              : DELAY_W'(1);

    // doubling saturates at the ceiling without wrapping
    assign doubled = (delay_reg > (max_backoff_reg >> 1)) ? max_backoff_reg
                                                          : {delay_reg[DELAY_W-2:0], 1'b0};

    always_comb
    begin
        enabled_next     = enabled_reg;
        cfg_ok_next      = cfg_ok_reg;
        start_delay_next = start_delay_reg;
        max_backoff_next = max_backoff_reg;
        state_next       = state_reg;
        delay_next       = delay_reg;
        deadline_next    = deadline_reg;
        act              = ACT_NONE;
        case (item.mode)
            MODE_TICK:
            begin
                if (!enabled_reg)
                begin
                    state_next = ST_DISABLED;
                    act        = is_active ? ACT_DISCONNECT : ACT_NONE;
                end
                else if (!cfg_ok_reg)
                begin
                    state_next = ST_FAULT;
                end
                else if (!item.network_up)
                begin
                    state_next = ST_WAITNET;
                    act        = is_active ? ACT_DISCONNECT : ACT_NONE;
                end
                else if (state_reg inside {ST_WAITNET, ST_READY})
                begin
                    state_next = ST_READY;
                    act        = ACT_CONNECT;
                end
                else if ((state_reg == ST_BACKOFF) && (now_ext >= deadline_reg))
                begin
                    state_next = ST_READY;
                    act        = ACT_CONNECT;
                end
            end
            MODE_CONNECTING:
            begin
                if (state_reg != ST_FAULT)
                begin
                    state_next = ST_CONNECTING;
                end
            end
            MODE_CONNECTED:
            begin
                state_next    = ST_ONLINE;
                delay_next    = start_delay_reg;
                deadline_next = '0;
            end
            MODE_DISCONNECTED:
            begin
                if (item.auth_failed)
                begin
                    state_next = ST_FAULT;
                end
                else if (!enabled_reg)
                begin
                    state_next = ST_DISABLED;
                end
                else
                begin
                    state_next    = ST_BACKOFF;
                    deadline_next = now_ext + {{(DEADLINE_W-DELAY_W){1'b0}}, delay_reg};
                    delay_next    = (doubled < max_backoff_reg) ? doubled : max_backoff_reg;
                end
            end
            MODE_RESTART:
            begin
                enabled_next     = cfg.link_enabled;
                cfg_ok_next      = new_cfg_ok;
                start_delay_next = new_start_delay;
                max_backoff_next = cfg.max_backoff;
                delay_next       = new_start_delay;
                deadline_next    = '0;
                if (!cfg.link_enabled)
                begin
                    state_next = ST_DISABLED;
                end
                else
                begin
                    state_next = new_cfg_ok ? ST_WAITNET : ST_FAULT;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            cfg_ok_reg      <= 1'b0;
            start_delay_reg <= BASE_BACKOFF_RST;
            max_backoff_reg <= MAX_BACKOFF_RST;
            state_reg       <= ST_DISABLED;
            delay_reg       <= BASE_BACKOFF_RST;
            deadline_reg    <= '0;
        end
        else if (step_en)
        begin
            enabled_reg     <= enabled_next;
            cfg_ok_reg      <= cfg_ok_next;
            start_delay_reg <= start_delay_next;
            max_backoff_reg <= max_backoff_next;
            state_reg       <= state_next;
            delay_reg       <= delay_next;
            deadline_reg    <= deadline_next;
        end
    end

    assign result.action     = act;
    assign result.link_state = state_next;

    a_connected_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.mode == MODE_CONNECTED)
        |=> (state_reg == ST_ONLINE) && (deadline_reg == '0) && (delay_reg == start_delay_reg))
        else $error("connected event did not reset the backoff");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.mode == MODE_RESTART)
        |=> (deadline_reg == '0) && (delay_reg == start_delay_reg) && (delay_reg != '0))
        else $error("restart did not reload the delay");

    a_fault_needs_cause: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.mode == MODE_CONNECTING) && (state_reg == ST_FAULT)
        |=> (state_reg == ST_FAULT))
        else $error("connecting event left fault state");

endmodule

`default_nettype wire
